/* sv/dccd_pkg.sv */
// Shared constants, register indexes, framer phase codes and types for the
// packet deframer. No dependencies.
package dccd_pkg;

    // Field widths
    localparam int WIDTH_W   = 16;
    localparam int PRE_W     = 8;
    localparam int LEN_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int BIDX_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Packet storage depth and number of byte outputs
    localparam int MAX_BYTES = 6;
    localparam int OUT_BYTES = 6;

    // Queue between classifier and framer
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_MIN    = 3'd4;

    // Register reset values
    localparam logic [WIDTH_W-1:0] RST_ONE_MIN    = 16'd460;
    localparam logic [WIDTH_W-1:0] RST_ONE_LIMIT  = 16'd700;
    localparam logic [WIDTH_W-1:0] RST_ZERO_MIN   = 16'd900;
    localparam logic [WIDTH_W-1:0] RST_ZERO_LIMIT = 16'd10000;
    localparam logic [PRE_W-1:0]   RST_PRE_MIN    = 8'd12;

    // Framer phases
    localparam logic [1:0] PH_PREAMBLE = 2'd0;
    localparam logic [1:0] PH_START    = 2'd1;
    localparam logic [1:0] PH_DATA     = 2'd2;
    localparam logic [1:0] PH_END      = 2'd3;

    // Saturation limits and packet checks
    localparam logic [PRE_W-1:0]  PRE_SAT   = 8'hFF;
    localparam logic [LEN_W-1:0]  LEN_SAT   = 3'd7;
    localparam logic [LEN_W-1:0]  LEN_MIN   = 3'd3;
    localparam logic [LEN_W-1:0]  LEN_MAX   = 3'd6;
    localparam logic [BIDX_W-1:0] BIT_LAST  = 3'd7;
    localparam logic [BYTE_W-1:0] IDLE_ADDR = 8'hFF;
    localparam logic [BYTE_W-1:0] IDLE_DATA = 8'h00;

    // One classified pulse
    typedef struct packed {
        logic bad;   // pulse outside both windows
        logic bit_v; // decoded bit value when not bad
    } t_code;

    // Push side of the queue
    typedef struct packed {
        logic  valid;
        t_code code;
    } t_push;

    // Head of the queue as seen by the framer
    typedef struct packed {
        logic  valid;
        t_code code;
    } t_head;

endpackage

/* sv/dcc_packet_deframer_core.sv */
// A pulse accepted at the input is written to the queue and framed from its head;
// a packet closed by that pulse is on the output from the edge that frames it.
// Throughput: one pulse per cycle; the framer stalls only while a result waits
// in the output register, and the two-entry queue absorbs that on the input side.
// Reset (synchronous, active low): registers to defaults, framer to preamble,
// queue and output register empty. Packet byte store is not cleared.
module dcc_packet_deframer_core import dccd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [WIDTH_W-1:0]   i_pulse_width,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BYTE_W-1:0]    o_byte_0,
    output logic [BYTE_W-1:0]    o_byte_1,
    output logic [BYTE_W-1:0]    o_byte_2,
    output logic [BYTE_W-1:0]    o_byte_3,
    output logic [BYTE_W-1:0]    o_byte_4,
    output logic [BYTE_W-1:0]    o_byte_5,
    output logic [LEN_W-1:0]     o_byte_count,
    output logic [PRE_W-1:0]     o_preamble_length,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_push            push;
    t_head            head;
    logic             q_full;
    logic             pop;
    logic [PRE_W-1:0] pre_min;

    // Classifier and configuration
    dccd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pulse_width  (i_pulse_width),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_preamble_min (pre_min)
    );

    // Decoupling queue
    dccd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Framer and output register
    dccd_framer u_framer (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head),
        .o_pop             (pop),
        .i_preamble_min    (pre_min),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_byte_0          (o_byte_0),
        .o_byte_1          (o_byte_1),
        .o_byte_2          (o_byte_2),
        .o_byte_3          (o_byte_3),
        .o_byte_4          (o_byte_4),
        .o_byte_5          (o_byte_5),
        .o_byte_count      (o_byte_count),
        .o_preamble_length (o_preamble_length)
    );

endmodule

/* sv/dccd_front.sv */
// Front end: configuration registers and pulse-width classifier.
// Depends on dccd_pkg.
module dccd_front import dccd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [WIDTH_W-1:0]   i_pulse_width,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_q_full,
    output t_push                o_push,
    output logic [PRE_W-1:0]     o_preamble_min
);

    logic [WIDTH_W-1:0] r_one_min;
    logic [WIDTH_W-1:0] r_one_limit;
    logic [WIDTH_W-1:0] r_zero_min;
    logic [WIDTH_W-1:0] r_zero_limit;
    logic [PRE_W-1:0]   r_pre_min;
    logic               is_one;
    logic               is_zero;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_min    <= RST_ONE_MIN;
            r_one_limit  <= RST_ONE_LIMIT;
            r_zero_min   <= RST_ZERO_MIN;
            r_zero_limit <= RST_ZERO_LIMIT;
            r_pre_min    <= RST_PRE_MIN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ONE_MIN:    r_one_min    <= i_cfg_data;
                REG_ONE_LIMIT:  r_one_limit  <= i_cfg_data;
                REG_ZERO_MIN:   r_zero_min   <= i_cfg_data;
                REG_ZERO_LIMIT: r_zero_limit <= i_cfg_data;
                REG_PRE_MIN:    r_pre_min    <= i_cfg_data[PRE_W-1:0];
                default: ;
            endcase
        end
    end

    // Window compare; a one wins where windows overlap
    assign is_one  = (i_pulse_width >= r_one_min) && (i_pulse_width < r_one_limit);
    assign is_zero = (i_pulse_width >= r_zero_min) && (i_pulse_width < r_zero_limit);

    assign o_in_ready      = !i_q_full;
    assign o_push.valid    = i_in_valid && !i_q_full;
    assign o_push.code.bad   = !is_one && !is_zero;
    assign o_push.code.bit_v = is_one;
    assign o_preamble_min  = r_pre_min;

endmodule

/* sv/dccd_queue.sv */
// Short queue of classified pulses between front end and framer.
// Depends on dccd_pkg.
module dccd_queue import dccd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    output t_head o_head,
    input  logic  i_pop
);

    t_code              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_pop;

    localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(Q_DEPTH - 1);
    localparam logic [Q_CNT_W-1:0] CNT_FULL = Q_CNT_W'(Q_DEPTH);

    assign o_full       = (r_count == CNT_FULL);
    assign o_head.valid = (r_count != '0);
    assign o_head.code  = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    // Storage write
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.code;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push.valid, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/dccd_framer.sv */
// Back end: preamble/start/data/end framer, packet byte store, checks and
// the output register. Depends on dccd_pkg.
module dccd_framer import dccd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_head             i_head,
    output logic              o_pop,
    input  logic [PRE_W-1:0]  i_preamble_min,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_byte_0,
    output logic [BYTE_W-1:0] o_byte_1,
    output logic [BYTE_W-1:0] o_byte_2,
    output logic [BYTE_W-1:0] o_byte_3,
    output logic [BYTE_W-1:0] o_byte_4,
    output logic [BYTE_W-1:0] o_byte_5,
    output logic [LEN_W-1:0]  o_byte_count,
    output logic [PRE_W-1:0]  o_preamble_length
);

    logic [1:0]        r_phase,  n_phase;
    logic [PRE_W-1:0]  r_pre,    n_pre;
    logic [BIDX_W-1:0] r_bidx,   n_bidx;
    logic [BYTE_W-1:0] r_shift,  n_shift;
    logic [BYTE_W-1:0] r_xor,    n_xor;
    logic [LEN_W-1:0]  r_len,    n_len;
    logic [BYTE_W-1:0] r_bytes [MAX_BYTES];
    logic              store;
    logic              emit;
    logic              take;
    logic              out_free;
    logic [PRE_W-1:0]  pre_inc;
    logic [BYTE_W-1:0] shift_in;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_ob [OUT_BYTES];
    logic [BYTE_W-1:0] n_ob [OUT_BYTES];
    logic [LEN_W-1:0]  r_out_len;
    logic [PRE_W-1:0]  r_out_pre;

    // Framer advances only when a result could be parked
    assign out_free = !r_out_valid || i_out_ready;
    assign o_pop    = i_head.valid && out_free;
    assign take     = o_pop;

    assign pre_inc  = (r_pre == PRE_SAT) ? r_pre : r_pre + 1'b1;
    assign shift_in = {r_shift[BYTE_W-2:0], i_head.code.bit_v};

    // Next-state logic for one pulse
    always_comb begin
        n_phase = r_phase;
        n_pre   = r_pre;
        n_bidx  = r_bidx;
        n_shift = r_shift;
        n_xor   = r_xor;
        n_len   = r_len;
        store   = 1'b0;
        emit    = 1'b0;
        if (i_head.code.bad) begin
            n_phase = PH_PREAMBLE;
            n_pre   = '0;
            n_bidx  = '0;
            n_shift = '0;
            n_xor   = '0;
            n_len   = '0;
        end else begin
            case (r_phase)
                PH_START: begin
                    if (i_head.code.bit_v) begin
                        n_pre = pre_inc;
                    end else begin
                        n_len   = '0;
                        n_xor   = '0;
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_shift = shift_in;
                    if (r_bidx == BIT_LAST) begin
                        n_bidx  = '0;
                        store   = (int'(r_len) < MAX_BYTES);
                        n_len   = (r_len == LEN_SAT) ? r_len : r_len + 1'b1;
                        n_xor   = r_xor ^ shift_in;
                        n_phase = PH_END;
                    end else begin
                        n_bidx = r_bidx + 1'b1;
                    end
                end
                PH_END: begin
                    if (!i_head.code.bit_v) begin
                        n_phase = PH_DATA;
                    end else begin
                        // good check, legal length, and not the idle packet
                        emit = (r_xor == '0) && (r_len >= LEN_MIN) && (r_len <= LEN_MAX)
                            && (int'(r_len) <= MAX_BYTES)
                            && !((r_len == LEN_MIN) && (r_bytes[0] == IDLE_ADDR)
                                 && (r_bytes[1] == IDLE_DATA));
                        n_phase = PH_PREAMBLE;
                        n_pre   = '0;
                    end
                end
                default: begin
                    if (i_head.code.bit_v) begin
                        n_pre = pre_inc;
                        if (pre_inc >= i_preamble_min) begin
                            n_phase = PH_START;
                        end
                    end else begin
                        n_pre = '0;
                    end
                end
            endcase
        end
    end

    // Framer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREAMBLE;
            r_pre   <= '0;
            r_bidx  <= '0;
            r_shift <= '0;
            r_xor   <= '0;
            r_len   <= '0;
        end else if (take) begin
            r_phase <= n_phase;
            r_pre   <= n_pre;
            r_bidx  <= n_bidx;
            r_shift <= n_shift;
            r_xor   <= n_xor;
            r_len   <= n_len;
        end
    end

    // Packet byte store, written at the current byte count
    always_ff @(posedge i_clk) begin
        for (int e = 0; e < MAX_BYTES; e++) begin
            if (take && store && (int'(r_len) == e)) begin
                r_bytes[e] <= shift_in;
            end
        end
    end

    // Result bytes; unused positions read as zero
    always_comb begin
        for (int k = 0; k < OUT_BYTES; k++) begin
            n_ob[k] = '0;
            if ((k < MAX_BYTES) && (k < int'(r_len))) begin
                n_ob[k] = r_bytes[k % MAX_BYTES];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            for (int k = 0; k < OUT_BYTES; k++) begin
                r_ob[k] <= n_ob[k];
            end
            r_out_len <= r_len;
            r_out_pre <= r_pre;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_byte_0          = r_ob[0];
    assign o_byte_1          = r_ob[1];
    assign o_byte_2          = r_ob[2];
    assign o_byte_3          = r_ob[3];
    assign o_byte_4          = r_ob[4];
    assign o_byte_5          = r_ob[5];
    assign o_byte_count      = r_out_len;
    assign o_preamble_length = r_out_pre;

endmodule
